FILE: rtl/fspa_pkg.sv
`default_nettype none
package fspa_pkg;

  localparam int STORE_ITEMS = 1024;
  localparam int INDEX_SLOTS = 1024;
  localparam int CAPACITY = (STORE_ITEMS > INDEX_SLOTS) ? INDEX_SLOTS : STORE_ITEMS;
  localparam int ADDR_W = $clog2(CAPACITY);

  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;

  localparam logic [COUNT_W-1:0] CLUTCH_MIN = 11'd15;
  localparam logic [COUNT_W-1:0] CLUTCH_MAX = 11'd1024;
  localparam logic [COUNT_W-1:0] CLUTCH_RESET = 11'd64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam logic [COUNT_W:0] CAPACITY_W = (COUNT_W + 1)'(CAPACITY);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
  localparam logic [1:0] STATUS_FREED = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mem_read;
    logic pop;
  } ctl_cmd_t;

  typedef struct packed {
    logic pop_needed;
  } ctl_sts_t;

endpackage
`default_nettype wire

FILE: rtl/fspa_ifs.sv
`default_nettype none
interface fspa_req_if;
  logic valid;
  logic ready;
  logic cmd;
  logic item_present;
  logic [fspa_pkg::INDEX_W-1:0] item_index;
  modport source (output valid, output cmd, output item_present, output item_index,
                  input ready);
  modport sink (input valid, input cmd, input item_present, input item_index,
                output ready);
endinterface

interface fspa_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [fspa_pkg::INDEX_W-1:0] granted_index;
  logic [fspa_pkg::COUNT_W-1:0] allocated_count;
  logic [fspa_pkg::COUNT_W-1:0] assembled_count;
  modport source (output valid, output status, output granted_index,
                  output allocated_count, output assembled_count, input ready);
  modport sink (input valid, input status, input granted_index,
                input allocated_count, input assembled_count, output ready);
endinterface

interface fspa_cfg_if;
  logic valid;
  logic ready;
  logic [fspa_pkg::COUNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/fspa_ctrl.sv
`default_nettype none
module fspa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire fspa_pkg::ctl_sts_t  sts,
  output fspa_pkg::ctl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_t;

  state_t state;
  logic out_free;

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.mem_read = sts.pop_needed;
          cmd.exec = !sts.pop_needed;
        end
      end
      ST_POP: begin
        cmd.pop = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A result is loaded only while the output register is free.
      if (cmd.exec || cmd.pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            if (sts.pop_needed) begin
              state <= ST_POP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_POP: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fspa_datapath.sv
`default_nettype none
module fspa_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fspa_pkg::ctl_cmd_t                  cmd,
  output fspa_pkg::ctl_sts_t                       sts,
  input  wire logic                                in_cmd,
  input  wire logic                                in_item_present,
  input  wire logic [fspa_pkg::INDEX_W-1:0]        in_item_index,
  input  wire logic                                cfg_valid,
  input  wire logic [fspa_pkg::COUNT_W-1:0]        cfg_data,
  output logic [1:0]                               out_status,
  output logic [fspa_pkg::INDEX_W-1:0]             out_granted_index,
  output logic [fspa_pkg::COUNT_W-1:0]             out_allocated_count,
  output logic [fspa_pkg::COUNT_W-1:0]             out_assembled_count
);

  localparam int IW = fspa_pkg::INDEX_W;
  localparam int CW = fspa_pkg::COUNT_W;
  localparam int AW = fspa_pkg::ADDR_W;

  // Request registers.
  logic req_cmd;
  logic req_present;
  logic [IW-1:0] req_index;

  logic [CW-1:0] items_per_clutch;

  logic [IW-1:0] list_head;
  logic list_nonempty;
  logic [IW-1:0] fresh_next;
  logic [CW-1:0] fresh_left;
  logic [CW-1:0] allocated_total;
  logic [CW-1:0] assembled_total;

  // Each entry holds the tail flag above the link to the next free item.
  logic [IW:0] link_mem [fspa_pkg::CAPACITY];
  logic [IW:0] rd_q;

  logic free_take;
  logic [CW-1:0] clutch;
  logic [CW:0] clutch_end;
  logic opening;
  logic [CW-1:0] left_eff;
  logic [IW-1:0] next_eff;
  logic fresh_got;
  logic [CW-1:0] alloc_inc;
  logic [CW-1:0] alloc_dec;

  assign sts.pop_needed = (req_cmd == fspa_pkg::CMD_ALLOC) && list_nonempty;

  assign free_take = req_present && ({2'b0, req_index} < fspa_pkg::CAPACITY_W);

  always_comb begin
    if (items_per_clutch < fspa_pkg::CLUTCH_MIN) begin
      clutch = fspa_pkg::CLUTCH_MIN;
    end else if (items_per_clutch > fspa_pkg::CLUTCH_MAX) begin
      clutch = fspa_pkg::CLUTCH_MAX;
    end else begin
      clutch = items_per_clutch;
    end
  end

  assign clutch_end = {1'b0, assembled_total} + {1'b0, clutch};
  assign opening = (fresh_left == '0) && (clutch_end <= fspa_pkg::CAPACITY_W);
  assign left_eff = opening ? clutch : fresh_left;
  assign next_eff = opening ? assembled_total[IW-1:0] : fresh_next;
  assign fresh_got = (left_eff != '0);

  assign alloc_inc = (allocated_total == fspa_pkg::COUNT_MAX) ? allocated_total
                                                              : allocated_total + 1'b1;
  assign alloc_dec = (allocated_total == '0) ? allocated_total : allocated_total - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.exec && (req_cmd == fspa_pkg::CMD_FREE) && free_take) begin
      link_mem[req_index[AW-1:0]] <= {!list_nonempty, list_head};
    end
    if (cmd.mem_read) begin
      rd_q <= link_mem[list_head[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd <= in_cmd;
      req_present <= in_item_present;
      req_index <= in_item_index;
    end
    if (cmd.pop) begin
      out_status <= fspa_pkg::STATUS_ALLOCATED;
      out_granted_index <= list_head;
      out_allocated_count <= alloc_inc;
      out_assembled_count <= assembled_total;
    end else if (cmd.exec) begin
      if (req_cmd == fspa_pkg::CMD_FREE) begin
        out_status <= fspa_pkg::STATUS_FREED;
        out_granted_index <= '0;
        out_allocated_count <= free_take ? alloc_dec : allocated_total;
        out_assembled_count <= assembled_total;
      end else if (fresh_got) begin
        out_status <= fspa_pkg::STATUS_ALLOCATED;
        out_granted_index <= next_eff;
        out_allocated_count <= alloc_inc;
        out_assembled_count <= opening ? clutch_end[CW-1:0] : assembled_total;
      end else begin
        out_status <= fspa_pkg::STATUS_EXHAUSTED;
        out_granted_index <= '0;
        out_allocated_count <= allocated_total;
        out_assembled_count <= assembled_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      items_per_clutch <= fspa_pkg::CLUTCH_RESET;
      list_head <= '0;
      list_nonempty <= 1'b0;
      fresh_next <= '0;
      fresh_left <= '0;
      allocated_total <= '0;
      assembled_total <= '0;
    end else begin
      if (cfg_valid) begin
        items_per_clutch <= cfg_data;
      end
      if (cmd.pop) begin
        if (rd_q[IW]) begin
          list_nonempty <= 1'b0;
        end else begin
          list_head <= rd_q[IW-1:0];
        end
        allocated_total <= alloc_inc;
      end else if (cmd.exec) begin
        if (req_cmd == fspa_pkg::CMD_FREE) begin
          if (free_take) begin
            list_head <= req_index;
            list_nonempty <= 1'b1;
            allocated_total <= alloc_dec;
          end
        end else if (fresh_got) begin
          // A new clutch opens right after every item assembled so far.
          if (opening) begin
            assembled_total <= clutch_end[CW-1:0];
          end
          fresh_left <= left_eff - 1'b1;
          fresh_next <= next_eff + 1'b1;
          allocated_total <= alloc_inc;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fixed_size_item_pool_allocator.sv
// Fixed-size item pool allocator.
// The req channel carries one request: cmd selects allocate or free, and a
// free gives item_present and item_index. Every request returns exactly one
// result on the rsp channel: a status, the granted index for an allocate,
// and the allocated and assembled counts after the request.
// The cfg channel writes items_per_clutch; it is always ready and should be
// written only while no request is in flight.
// For a free, an allocate from a fresh clutch and a refused allocate the
// result is loaded into the output register from the execute state once
// the output register is free. An allocate that pops the free list passes
// through an extra pop state before its result is loaded, because the
// link of the list head comes from a synchronous link memory read.
// One request is worked on at a time; req.ready is high only when idle.
// While rsp is stalled the finished result holds in the output register and
// the next request is taken, but its result waits until the output drains.
// Reset empties the free list, clears all counts and sets items_per_clutch
// to 64. The link memory needs no clearing; only entries written by a free
// are ever read.
`default_nettype none
module fixed_size_item_pool_allocator (
  input wire logic clk,
  input wire logic rst,
  fspa_req_if.sink   req,
  fspa_rsp_if.source rsp,
  fspa_cfg_if.sink   cfg
);

  fspa_pkg::ctl_cmd_t cmd;
  fspa_pkg::ctl_sts_t sts;

  assign cfg.ready = 1'b1;

  fspa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fspa_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_cmd              (req.cmd),
    .in_item_present     (req.item_present),
    .in_item_index       (req.item_index),
    .cfg_valid           (cfg.valid),
    .cfg_data            (cfg.data),
    .out_status          (rsp.status),
    .out_granted_index   (rsp.granted_index),
    .out_allocated_count (rsp.allocated_count),
    .out_assembled_count (rsp.assembled_count)
  );

endmodule
`default_nettype wire
